// ----- hw/rtl/rmq_pkg.sv -----
// Shared types and constants of the rotation matrix to quaternion block.
// Used by rotation_matrix_to_quaternion and its assertion checker.
// Depends on nothing.
package rmq_pkg;

  localparam int FracBits   = 14;
  localparam int EntW       = 16;
  localparam int DW         = EntW + 2;
  localparam int RadW       = EntW + 3;
  localparam int NW         = 32;
  localparam int RootW      = NW / 2;
  localparam int SqRemW     = RootW + 2;
  localparam int SqPerStage = 2;
  localparam int SqStages   = RootW / SqPerStage;
  localparam int NumW       = EntW + 1 + FracBits;
  localparam int DenW       = RootW + 1;
  localparam int QW         = 24;
  localparam int PreW       = NumW - QW;
  localparam int DvRemW     = DenW + 1;
  localparam int DvPerStage = 3;
  localparam int DvStages   = QW / DvPerStage;
  localparam int Latency    = SqStages + DvStages + 4;

  localparam logic [1:0] SlotX = 2'd0;
  localparam logic [1:0] SlotY = 2'd1;
  localparam logic [1:0] SlotZ = 2'd2;
  localparam logic [1:0] SlotW = 2'd3;

  typedef struct packed {
    logic signed [EntW-1:0] m00;
    logic signed [EntW-1:0] m01;
    logic signed [EntW-1:0] m02;
    logic signed [EntW-1:0] m10;
    logic signed [EntW-1:0] m11;
    logic signed [EntW-1:0] m12;
    logic signed [EntW-1:0] m20;
    logic signed [EntW-1:0] m21;
    logic signed [EntW-1:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [EntW-1:0] qx;
    logic signed [EntW-1:0] qy;
    logic signed [EntW-1:0] qz;
    logic signed [EntW-1:0] qw;
    logic                   degenerate;
  } rmq_out_t;

  typedef struct packed {
    logic [1:0] diag;
    logic       degen;
  } rmq_ctl_t;

  typedef struct packed {
    logic [NW-1:0]     n;
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
  } rmq_sq_t;

  typedef struct packed {
    logic [DvRemW-1:0] rem;
    logic [QW-1:0]     n;
  } rmq_dv_t;

endpackage

// ----- hw/rtl/rotation_matrix_to_quaternion.sv -----
// Pipelined rotation matrix to quaternion converter (Shoemake's method).
// Depends on rmq_pkg for the payload structs and pipeline constants.
//
// Channel  Direction  Handshake          Payload
// input    in         start_i, busy_o    matrix_i (rmq_in_t)
// result   out        done_o             quat_o (rmq_out_t)
//
// One matrix may enter every cycle; busy_o is never raised.
// Each result passes the input and case registers, the square root (8 stages, 2 bits
// each), the operand register, the divider (8 stages, 3 bits each) and done_o's register.
// Reset clears all valid bits; the data registers are not reset.
// The receiver cannot stall, so the pipeline always advances.
module rotation_matrix_to_quaternion (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  rmq_pkg::rmq_in_t matrix_i,
  output logic             done_o,
  output rmq_pkg::rmq_out_t quat_o
);

  localparam logic signed [rmq_pkg::RadW-1:0] One = rmq_pkg::RadW'(1 << rmq_pkg::FracBits);

  function automatic rmq_pkg::rmq_sq_t sqrt_step(rmq_pkg::rmq_sq_t s);
    rmq_pkg::rmq_sq_t o;
    logic [rmq_pkg::SqRemW-1:0] r2;
    logic [rmq_pkg::SqRemW-1:0] trial;
    r2    = {s.rem[rmq_pkg::SqRemW-3:0], s.n[rmq_pkg::NW-1 -: 2]};
    trial = {s.root, 2'b01};
    o.n   = s.n << 2;
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[rmq_pkg::RootW-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[rmq_pkg::RootW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic rmq_pkg::rmq_dv_t div_step(rmq_pkg::rmq_dv_t s,
                                                 logic [rmq_pkg::DenW-1:0] den);
    rmq_pkg::rmq_dv_t o;
    logic [rmq_pkg::DvRemW-1:0] r2;
    logic [rmq_pkg::DvRemW-1:0] dx;
    r2 = {s.rem[rmq_pkg::DvRemW-2:0], s.n[rmq_pkg::QW-1]};
    dx = rmq_pkg::DvRemW'(den);
    if (r2 >= dx) begin
      o.rem = r2 - dx;
      o.n   = {s.n[rmq_pkg::QW-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.n   = {s.n[rmq_pkg::QW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [rmq_pkg::EntW-1:0] sat_q(logic neg, logic [rmq_pkg::QW-1:0] q);
    logic [rmq_pkg::EntW-1:0] r;
    if (neg) begin
      if (q > rmq_pkg::QW'(32768)) r = 16'h8000;
      else r = ~q[rmq_pkg::EntW-1:0] + 16'd1;
    end else begin
      if (q > rmq_pkg::QW'(32767)) r = 16'h7fff;
      else r = q[rmq_pkg::EntW-1:0];
    end
    return r;
  endfunction

  assign busy_o = 1'b0;

  // Input register.
  logic             vld0_q;
  rmq_pkg::rmq_in_t in0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in0_q <= matrix_i;
  end

  // Case selection and radicand.
  logic signed [rmq_pkg::DW-1:0]   tr;
  logic signed [rmq_pkg::EntW-1:0] mii;
  logic signed [rmq_pkg::RadW-1:0] rad;
  logic                            pos, i1, i2;
  logic [1:0]                      isel;
  rmq_pkg::rmq_ctl_t               ctl1_d;
  rmq_pkg::rmq_sq_t                sq1_d;
  logic signed [rmq_pkg::DW-1:0]   d1_d [4];
  logic signed [rmq_pkg::DW-1:0]   dif_x, dif_y, dif_z;

  always_comb begin
    tr    = rmq_pkg::DW'(in0_q.m00) + rmq_pkg::DW'(in0_q.m11) + rmq_pkg::DW'(in0_q.m22);
    pos   = tr > 0;
    i1    = in0_q.m11 > in0_q.m00;
    mii   = i1 ? in0_q.m11 : in0_q.m00;
    i2    = in0_q.m22 > mii;
    mii   = i2 ? in0_q.m22 : mii;
    isel  = i2 ? rmq_pkg::SlotZ : (i1 ? rmq_pkg::SlotY : rmq_pkg::SlotX);
    if (pos) begin
      rad = rmq_pkg::RadW'(tr) + One;
    end else begin
      rad = rmq_pkg::RadW'(mii) + rmq_pkg::RadW'(mii) - rmq_pkg::RadW'(tr) + One;
    end
    ctl1_d.diag  = pos ? rmq_pkg::SlotW : isel;
    ctl1_d.degen = rad <= 0;
    sq1_d.n      = ctl1_d.degen ? '0 :
                   (rmq_pkg::NW'(rad[rmq_pkg::EntW:0]) << rmq_pkg::FracBits);
    sq1_d.rem    = '0;
    sq1_d.root   = '0;
    dif_x = rmq_pkg::DW'(in0_q.m21) - rmq_pkg::DW'(in0_q.m12);
    dif_y = rmq_pkg::DW'(in0_q.m02) - rmq_pkg::DW'(in0_q.m20);
    dif_z = rmq_pkg::DW'(in0_q.m10) - rmq_pkg::DW'(in0_q.m01);
    if (pos) begin
      d1_d[0] = dif_x;
      d1_d[1] = dif_y;
      d1_d[2] = dif_z;
    end else begin
      d1_d[0] = (isel == rmq_pkg::SlotY) ?
                rmq_pkg::DW'(in0_q.m01) + rmq_pkg::DW'(in0_q.m10) :
                rmq_pkg::DW'(in0_q.m02) + rmq_pkg::DW'(in0_q.m20);
      d1_d[1] = (isel == rmq_pkg::SlotX) ?
                rmq_pkg::DW'(in0_q.m10) + rmq_pkg::DW'(in0_q.m01) :
                rmq_pkg::DW'(in0_q.m12) + rmq_pkg::DW'(in0_q.m21);
      d1_d[2] = (isel == rmq_pkg::SlotX) ?
                rmq_pkg::DW'(in0_q.m20) + rmq_pkg::DW'(in0_q.m02) :
                rmq_pkg::DW'(in0_q.m21) + rmq_pkg::DW'(in0_q.m12);
    end
    case (isel)
      rmq_pkg::SlotX: d1_d[3] = dif_x;
      rmq_pkg::SlotY: d1_d[3] = dif_y;
      default:        d1_d[3] = dif_z;
    endcase
  end

  logic                          vld1_q;
  rmq_pkg::rmq_ctl_t             ctl1_q;
  rmq_pkg::rmq_sq_t              sq1_q;
  logic signed [rmq_pkg::DW-1:0] d1_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl1_q <= ctl1_d;
    sq1_q  <= sq1_d;
    d1_q   <= d1_d;
  end

  // Square root stages.
  logic                          sv_q   [rmq_pkg::SqStages];
  rmq_pkg::rmq_ctl_t             sctl_q [rmq_pkg::SqStages];
  rmq_pkg::rmq_sq_t              ssq_q  [rmq_pkg::SqStages];
  rmq_pkg::rmq_sq_t              ssq_d  [rmq_pkg::SqStages];
  logic signed [rmq_pkg::DW-1:0] sd_q   [rmq_pkg::SqStages][4];

  for (genvar k = 0; k < rmq_pkg::SqStages; k++) begin : g_sq
    logic                          v_in;
    rmq_pkg::rmq_ctl_t             c_in;
    rmq_pkg::rmq_sq_t              s_in;
    logic signed [rmq_pkg::DW-1:0] d_in [4];

    if (k == 0) begin : g_first
      assign v_in = vld1_q;
      assign c_in = ctl1_q;
      assign s_in = sq1_q;
      assign d_in = d1_q;
    end else begin : g_next
      assign v_in = sv_q[k-1];
      assign c_in = sctl_q[k-1];
      assign s_in = ssq_q[k-1];
      assign d_in = sd_q[k-1];
    end

    always_comb begin
      rmq_pkg::rmq_sq_t t;
      t = s_in;
      for (int b = 0; b < rmq_pkg::SqPerStage; b++) begin
        t = sqrt_step(t);
      end
      ssq_d[k] = t;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else begin
        sv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sctl_q[k] <= c_in;
      ssq_q[k]  <= ssq_d[k];
      sd_q[k]   <= d_in;
    end
  end

  // Divider operand setup.
  localparam int SqLast = rmq_pkg::SqStages - 1;

  logic [rmq_pkg::RootW-1:0] rd;
  rmq_pkg::rmq_dv_t          dv_d  [4];
  logic [3:0]                neg_d;

  always_comb begin
    logic [rmq_pkg::DW-1:0]   mag;
    logic [rmq_pkg::NumW-1:0] num;
    rd = ssq_q[SqLast].root;
    for (int l = 0; l < 4; l++) begin
      neg_d[l]  = sd_q[SqLast][l] < 0;
      mag       = neg_d[l] ? -sd_q[SqLast][l] : sd_q[SqLast][l];
      num       = (rmq_pkg::NumW'(mag[rmq_pkg::EntW:0]) << rmq_pkg::FracBits) +
                  rmq_pkg::NumW'(rd);
      dv_d[l].rem = rmq_pkg::DvRemW'(num[rmq_pkg::NumW-1 -: rmq_pkg::PreW]);
      dv_d[l].n   = num[rmq_pkg::QW-1:0];
    end
  end

  logic                       vp_q;
  rmq_pkg::rmq_ctl_t          pctl_q;
  logic [3:0]                 pneg_q;
  logic [rmq_pkg::RootW-1:0]  phalf_q;
  logic [rmq_pkg::DenW-1:0]   pden_q;
  rmq_pkg::rmq_dv_t           pdv_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= sv_q[SqLast];
    end
  end

  always_ff @(posedge clk_i) begin
    pctl_q  <= sctl_q[SqLast];
    pneg_q  <= neg_d;
    phalf_q <= rmq_pkg::RootW'((rmq_pkg::DenW'(rd) + 1'b1) >> 1);
    pden_q  <= {rd, 1'b0};
    pdv_q   <= dv_d;
  end

  // Divider stages, one lane per quaternion component.
  logic                      vv_q    [rmq_pkg::DvStages];
  rmq_pkg::rmq_ctl_t         vctl_q  [rmq_pkg::DvStages];
  logic [3:0]                vneg_q  [rmq_pkg::DvStages];
  logic [rmq_pkg::RootW-1:0] vhalf_q [rmq_pkg::DvStages];
  logic [rmq_pkg::DenW-1:0]  vden_q  [rmq_pkg::DvStages];
  rmq_pkg::rmq_dv_t          vdv_q   [rmq_pkg::DvStages][4];
  rmq_pkg::rmq_dv_t          vdv_d   [rmq_pkg::DvStages][4];

  for (genvar k = 0; k < rmq_pkg::DvStages; k++) begin : g_dv
    logic                      v_in;
    rmq_pkg::rmq_ctl_t         c_in;
    logic [3:0]                n_in;
    logic [rmq_pkg::RootW-1:0] h_in;
    logic [rmq_pkg::DenW-1:0]  den_in;
    rmq_pkg::rmq_dv_t          dv_in [4];

    if (k == 0) begin : g_first
      assign v_in   = vp_q;
      assign c_in   = pctl_q;
      assign n_in   = pneg_q;
      assign h_in   = phalf_q;
      assign den_in = pden_q;
      assign dv_in  = pdv_q;
    end else begin : g_next
      assign v_in   = vv_q[k-1];
      assign c_in   = vctl_q[k-1];
      assign n_in   = vneg_q[k-1];
      assign h_in   = vhalf_q[k-1];
      assign den_in = vden_q[k-1];
      assign dv_in  = vdv_q[k-1];
    end

    always_comb begin
      rmq_pkg::rmq_dv_t t;
      for (int l = 0; l < 4; l++) begin
        t = dv_in[l];
        for (int b = 0; b < rmq_pkg::DvPerStage; b++) begin
          t = div_step(t, den_in);
        end
        vdv_d[k][l] = t;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vv_q[k] <= 1'b0;
      end else begin
        vv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      vctl_q[k]  <= c_in;
      vneg_q[k]  <= n_in;
      vhalf_q[k] <= h_in;
      vden_q[k]  <= den_in;
      vdv_q[k]   <= vdv_d[k];
    end
  end

  // Final selection and saturation.
  localparam int DvLast = rmq_pkg::DvStages - 1;

  logic [rmq_pkg::EntW-1:0] comp [4];
  rmq_pkg::rmq_out_t        out_d;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (vctl_q[DvLast].degen) begin
        comp[l] = '0;
      end else if (vctl_q[DvLast].diag == 2'(l)) begin
        comp[l] = vhalf_q[DvLast];
      end else begin
        comp[l] = sat_q(vneg_q[DvLast][l], vdv_q[DvLast][l].n);
      end
    end
    out_d.qx         = comp[0];
    out_d.qy         = comp[1];
    out_d.qz         = comp[2];
    out_d.qw         = comp[3];
    out_d.degenerate = vctl_q[DvLast].degen;
  end

  logic              done_q;
  rmq_pkg::rmq_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vv_q[DvLast];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign quat_o = out_q;

endmodule

// ----- hw/rtl/rmq_checker.sv -----
// Port-level checker for rotation_matrix_to_quaternion, bound to the top level.
// Depends on rmq_pkg for the result struct and the pipeline latency.
module rmq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input rmq_pkg::rmq_out_t quat_o
);

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised on a pipeline that never stalls");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(rmq_pkg::Latency) done_o)
    else $error("result transfer missing after an input transfer");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && quat_o.degenerate) |->
      (quat_o.qx == '0 && quat_o.qy == '0 && quat_o.qz == '0 && quat_o.qw == '0))
    else $error("degenerate result with nonzero components");

  a_reset_quiet: assert property (@(posedge clk_i) $rose(rst_ni) |-> !done_o)
    else $error("result strobe right after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .quat_o  (quat_o)
);
